/* rtl/rce_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types and constants for the RIFF chunk extractor.
// ----------------------------------------------------------------------------
package rce_pkg;

    localparam logic [31:0] TAG_RIFF  = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE  = 32'h4556_4157;
    localparam logic [31:0] TAG_IXML  = 32'h4C4D_5869;

    localparam logic [3:0]  FILE_HDR_LAST  = 4'd11;
    localparam logic [3:0]  CHUNK_HDR_LAST = 4'd7;
    localparam logic [3:0]  TAG_BYTES      = 4'd4;
    localparam logic [3:0]  SIZE_BYTES_END = 4'd8;

    localparam logic [2:0]  OC_BYTE       = 3'd0;
    localparam logic [2:0]  OC_EMPTY      = 3'd1;
    localparam logic [2:0]  OC_BAD_HEADER = 3'd2;
    localparam logic [2:0]  OC_TRUNCATED  = 3'd3;
    localparam logic [2:0]  OC_NOT_FOUND  = 3'd4;

    typedef enum logic [4:0] {
        PH_FILE_HDR  = 5'b00001,
        PH_CHUNK_HDR = 5'b00010,
        PH_PAYLOAD   = 5'b00100,
        PH_SKIP      = 5'b01000,
        PH_DONE      = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic [2:0] outcome;
    } result_t;

endpackage
`default_nettype wire

/* rtl/rce_input_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rce_input_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module rce_input_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire rce_pkg::item_t s_item,
    input  wire logic          advance,
    output logic               item_valid,
    output rce_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    rce_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/rce_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rce_parser
// Header check, chunk walk and payload pass-through; one byte per cycle unless the result register is stalled.
// ----------------------------------------------------------------------------
module rce_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wr_en,
    input  wire logic [31:0]    cfg_wr_data,
    input  wire logic           fire,
    input  wire rce_pkg::item_t item,
    output logic                res_valid,
    output rce_pkg::result_t    res,
    output rce_pkg::phase_t     phase
);

    logic [31:0]     target_reg;
    rce_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      count_reg, count_next;
    logic            mismatch_reg, mismatch_next;
    logic [31:0]     id_reg, id_next;
    logic [31:0]     size_reg, size_next;
    logic [32:0]     remain_reg, remain_next;

    logic [7:0]      b;
    logic            eof;
    logic [31:0]     tag;
    logic [7:0]      want;
    logic            mismatch_now;
    logic [31:0]     size_new;
    logic [32:0]     remain_dec;

    assign b     = item.stream_byte;
    assign eof   = item.end_of_file;
    assign phase = phase_reg;

    assign tag          = (count_reg < rce_pkg::TAG_BYTES) ? rce_pkg::TAG_RIFF
                                                           : rce_pkg::TAG_WAVE;
    assign want         = tag[{count_reg[1:0], 3'b000} +: 8];
    assign mismatch_now = mismatch_reg
                          || ((count_reg < rce_pkg::TAG_BYTES
                               || count_reg >= rce_pkg::SIZE_BYTES_END)
                              && b != want);
    assign size_new     = {b, size_reg[31:8]};
    assign remain_dec   = (remain_reg != '0) ? remain_reg - 33'd1 : remain_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        mismatch_next = mismatch_reg;
        id_next       = id_reg;
        size_next     = size_reg;
        remain_next   = remain_reg;
        res_valid     = 1'b0;
        res           = '0;

        unique case (phase_reg)
            rce_pkg::PH_FILE_HDR:
            begin
                mismatch_next = mismatch_now;
                if (count_reg == rce_pkg::FILE_HDR_LAST)
                begin
                    count_next = '0;
                    if (mismatch_now)
                    begin
                        res_valid  = 1'b1;
                        res        = '{8'd0, 1'b1, rce_pkg::OC_BAD_HEADER};
                        phase_next = rce_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = rce_pkg::PH_CHUNK_HDR;
                    end
                end
                else
                begin
                    count_next = count_reg + 4'd1;
                end
                if (eof && !res_valid)
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, 1'b1,
                                  (count_reg == rce_pkg::FILE_HDR_LAST)
                                  ? rce_pkg::OC_NOT_FOUND : rce_pkg::OC_BAD_HEADER};
                end
            end
            rce_pkg::PH_CHUNK_HDR:
            begin
                if (count_reg < rce_pkg::TAG_BYTES)
                begin
                    id_next = {b, id_reg[31:8]};
                end
                else
                begin
                    size_next = size_new;
                end
                if (count_reg == rce_pkg::CHUNK_HDR_LAST)
                begin
                    count_next = '0;
                    if (id_reg == target_reg)
                    begin
                        if (size_new == '0)
                        begin
                            res_valid  = 1'b1;
                            res        = '{8'd0, 1'b1, rce_pkg::OC_EMPTY};
                            phase_next = rce_pkg::PH_DONE;
                        end
                        else
                        begin
                            remain_next = {1'b0, size_new};
                            phase_next  = rce_pkg::PH_PAYLOAD;
                            if (eof)
                            begin
                                res_valid = 1'b1;
                                res       = '{8'd0, 1'b1, rce_pkg::OC_TRUNCATED};
                            end
                        end
                    end
                    else
                    begin
                        // odd sized chunks carry one pad byte
                        remain_next = {1'b0, size_new} + {32'd0, size_new[0]};
                        phase_next  = (size_new == '0) ? rce_pkg::PH_CHUNK_HDR
                                                       : rce_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    count_next = count_reg + 4'd1;
                end
                if (eof && !res_valid)
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, 1'b1, rce_pkg::OC_NOT_FOUND};
                end
            end
            rce_pkg::PH_PAYLOAD:
            begin
                remain_next = remain_dec;
                res_valid   = 1'b1;
                if (remain_dec == '0)
                begin
                    res        = '{b, 1'b1, rce_pkg::OC_BYTE};
                    phase_next = rce_pkg::PH_DONE;
                end
                else if (eof)
                begin
                    res = '{8'd0, 1'b1, rce_pkg::OC_TRUNCATED};
                end
                else
                begin
                    res = '{b, 1'b0, rce_pkg::OC_BYTE};
                end
            end
            rce_pkg::PH_SKIP:
            begin
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_next = rce_pkg::PH_CHUNK_HDR;
                end
                if (eof)
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, 1'b1, rce_pkg::OC_NOT_FOUND};
                end
            end
            default:
            begin
                // done: drop bytes until end of file
            end
        endcase

        if (eof)
        begin
            phase_next    = rce_pkg::PH_FILE_HDR;
            count_next    = '0;
            mismatch_next = 1'b0;
            id_next       = '0;
            size_next     = '0;
            remain_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= rce_pkg::TAG_IXML;
            phase_reg    <= rce_pkg::PH_FILE_HDR;
            count_reg    <= '0;
            mismatch_reg <= 1'b0;
            id_reg       <= '0;
            size_reg     <= '0;
            remain_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                mismatch_reg <= mismatch_next;
                id_reg       <= id_next;
                size_reg     <= size_next;
                remain_reg   <= remain_next;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/rce_output_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rce_output_stage
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
module rce_output_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire rce_pkg::result_t res,
    output logic                  can_load,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output rce_pkg::result_t      m_res
);

    logic             valid_reg;
    logic             valid_next;
    rce_pkg::result_t res_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

/* rtl/riff_chunk_extractor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// riff_chunk_extractor
// Streaming RIFF/WAVE chunk extractor with a configurable chunk id.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the file one byte per transaction on s_tdata; assert s_tlast on the
//   final byte of the file. cfg_wr_data written with cfg_wr_en sets the chunk
//   id to extract (first id byte in bits 7:0); write it only while idle.
//   Results leave on m_*: m_tdata is the payload byte, m_tuser the outcome
//   (payload byte, empty chunk, bad header, truncated payload, not found)
//   and m_tlast marks the final payload byte and every status result.
//   An accepted byte sits in the input register; its result is then
//   loaded into the result register, which drives m_*. Throughput: one
//   byte per cycle while the result register is free or being drained;
//   the single decode step between the input and result registers sets it.
//   A byte that produces no result also moves on, unless the result
//   register is full and stalled.
//   When the receiver stalls, the result register holds and the input
//   register fills, after which s_tready drops; nothing is lost.
//   Reset clears the parser to the file header phase and loads id 'iXML'.
//   After an end-of-file byte the parser rearms; the chunk id is kept.
// ----------------------------------------------------------------------------
module riff_chunk_extractor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  wire logic        s_tlast,   // end_of_file
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] payload_byte
    output logic             m_tlast,   // last_byte
    output logic [2:0]       m_tuser    // [2:0] outcome
);

    rce_pkg::item_t   s_item;
    rce_pkg::item_t   item;
    logic             item_valid;
    logic             can_load;
    logic             fire;
    logic             res_valid;
    rce_pkg::result_t res;
    rce_pkg::result_t m_res;
    rce_pkg::phase_t  phase;

    assign s_item = '{s_tdata, s_tlast};
    // advance the held byte only when its result, if any, has a place to go
    assign fire   = item_valid && can_load;

    rce_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    rce_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .res_valid   (res_valid),
        .res         (res),
        .phase       (phase)
    );

    rce_output_stage u_output (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = m_res.payload_byte;
    assign m_tlast = m_res.last_byte;
    assign m_tuser = m_res.outcome;

`ifndef SYNTHESIS
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != rce_pkg::OC_BYTE |-> m_tlast && m_tdata == 8'd0)
        else $error("status result without last mark or with payload");

    a_rearm_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_file |=> phase == rce_pkg::PH_FILE_HDR)
        else $error("parser did not rearm after end of file");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |-> !m_tvalid || m_tready)
        else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire

/* verif/rce_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rce_checker
// Watches the stream and configuration ports of the RIFF chunk extractor,
// models the parser byte by byte and compares every output transaction
// with the oldest predicted one. Counts failures and reports how many
// predicted outputs are still waiting.
// ----------------------------------------------------------------------------
module rce_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  wire logic        s_tlast,   // end_of_file
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [7:0] payload_byte
    input  wire logic        m_tlast,   // last_byte
    input  wire logic [2:0]  m_tuser,   // [2:0] outcome
    output int               mismatches,
    output int               outstanding
);

    logic [31:0]      target_id;
    rce_pkg::phase_t  phase;
    logic [3:0]       hdr_count;
    logic             hdr_bad;
    logic [31:0]      chunk_id;
    logic [31:0]      chunk_size;
    logic [32:0]      left;

    rce_pkg::result_t parser_out_q[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic clear_parser();
        phase      = rce_pkg::PH_FILE_HDR;
        hdr_count  = '0;
        hdr_bad    = 1'b0;
        chunk_id   = '0;
        chunk_size = '0;
        left       = '0;
    endtask

    function automatic rce_pkg::result_t status_result(input logic [2:0] oc);
        rce_pkg::result_t r;
        r              = '0;
        r.last_byte    = 1'b1;
        r.outcome      = oc;
        return r;
    endfunction

    // Advance the parser by one file byte; queue the output it causes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic eof);
        logic [3:0]       k;
        logic [31:0]      tag;
        logic             emit;
        rce_pkg::result_t r;
        emit = 1'b0;
        r    = '0;
        k    = hdr_count;
        case (phase)
            rce_pkg::PH_FILE_HDR:
            begin
                // size field (bytes 4..7) is not checked
                if (k < rce_pkg::TAG_BYTES || k >= rce_pkg::SIZE_BYTES_END)
                begin
                    tag = (k < rce_pkg::TAG_BYTES) ? rce_pkg::TAG_RIFF : rce_pkg::TAG_WAVE;
                    if (b != tag[8 * k[1:0] +: 8])
                        hdr_bad = 1'b1;
                end
                if (k == rce_pkg::FILE_HDR_LAST)
                begin
                    hdr_count = '0;
                    if (hdr_bad)
                    begin
                        emit  = 1'b1;
                        r     = status_result(rce_pkg::OC_BAD_HEADER);
                        phase = rce_pkg::PH_DONE;
                    end
                    else
                        phase = rce_pkg::PH_CHUNK_HDR;
                end
                else
                    hdr_count = k + 4'd1;
                if (eof && !emit)
                begin
                    emit = 1'b1;
                    r    = status_result((phase == rce_pkg::PH_FILE_HDR)
                                         ? rce_pkg::OC_BAD_HEADER
                                         : rce_pkg::OC_NOT_FOUND);
                end
            end
            rce_pkg::PH_CHUNK_HDR:
            begin
                if (k < rce_pkg::TAG_BYTES)
                    chunk_id = {b, chunk_id[31:8]};
                else
                    chunk_size = {b, chunk_size[31:8]};
                if (k == rce_pkg::CHUNK_HDR_LAST)
                begin
                    hdr_count = '0;
                    if (chunk_id == target_id)
                    begin
                        if (chunk_size == '0)
                        begin
                            emit  = 1'b1;
                            r     = status_result(rce_pkg::OC_EMPTY);
                            phase = rce_pkg::PH_DONE;
                        end
                        else
                        begin
                            left  = {1'b0, chunk_size};
                            phase = rce_pkg::PH_PAYLOAD;
                            if (eof)
                            begin
                                emit = 1'b1;
                                r    = status_result(rce_pkg::OC_TRUNCATED);
                            end
                        end
                    end
                    else
                    begin
                        // odd sizes carry one pad byte
                        left  = {1'b0, chunk_size} + 33'(chunk_size[0]);
                        phase = (left == '0) ? rce_pkg::PH_CHUNK_HDR : rce_pkg::PH_SKIP;
                    end
                end
                else
                    hdr_count = k + 4'd1;
                if (eof && !emit)
                begin
                    emit = 1'b1;
                    r    = status_result(rce_pkg::OC_NOT_FOUND);
                end
            end
            rce_pkg::PH_PAYLOAD:
            begin
                if (left != '0)
                    left = left - 33'd1;
                emit = 1'b1;
                if (left == '0)
                begin
                    r.payload_byte = b;
                    r.last_byte    = 1'b1;
                    r.outcome      = rce_pkg::OC_BYTE;
                    phase          = rce_pkg::PH_DONE;
                end
                else if (eof)
                    r = status_result(rce_pkg::OC_TRUNCATED);
                else
                begin
                    r.payload_byte = b;
                    r.outcome      = rce_pkg::OC_BYTE;
                end
            end
            rce_pkg::PH_SKIP:
            begin
                if (left != '0)
                    left = left - 33'd1;
                if (left == '0)
                    phase = rce_pkg::PH_CHUNK_HDR;
                if (eof)
                begin
                    emit = 1'b1;
                    r    = status_result(rce_pkg::OC_NOT_FOUND);
                end
            end
            default:
            begin
                // done: drop bytes until end of file
            end
        endcase
        if (emit)
            parser_out_q = {parser_out_q, r};
        if (eof)
            clear_parser();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rce_pkg::result_t want;
        if (!rst_n)
        begin
            target_id = rce_pkg::TAG_IXML;
            clear_parser();
            parser_out_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                target_id = cfg_wr_data;

            if (m_tvalid && m_tready)
            begin
                if (parser_out_q.size() == 0)
                    report_mismatch($sformatf("output transaction with none pending: %h/%b/%0d",
                                              m_tdata, m_tlast, m_tuser));
                else
                begin
                    want = parser_out_q.pop_front();
                    if (m_tdata != want.payload_byte)
                        report_mismatch($sformatf("payload_byte %h, want %h",
                                                  m_tdata, want.payload_byte));
                    if (m_tlast != want.last_byte)
                        report_mismatch($sformatf("last_byte %b, want %b",
                                                  m_tlast, want.last_byte));
                    if (m_tuser != want.outcome)
                        report_mismatch($sformatf("outcome %0d, want %0d",
                                                  m_tuser, want.outcome));
                end
            end

            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
        end
        outstanding = parser_out_q.size();
    end

endmodule
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Top of the RIFF chunk extractor testbench. Feeds whole files byte by byte:
// a few directed files, then random files (well-formed with random content,
// corrupted headers, cut files and noise) under several chunk id settings,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_BYTES  = 40;
    localparam int BODY_CAP     = 48;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;   // [7:0] stream_byte
    logic        s_tlast     = 1'b0; // end_of_file
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] payload_byte
    logic        m_tlast;            // last_byte
    logic [2:0]  m_tuser;            // [2:0] outcome

    int          mismatches;
    int          outstanding;
    int          cycles     = 0;
    int          stall_left = 0;
    int          bytes_sent = 0;
    bit          quiet      = 1'b0;
    logic [31:0] target_id  = rce_pkg::TAG_IXML;
    logic [7:0]  file_q[$];

    riff_chunk_extractor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    rce_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Output side: stall in random bursts.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic append_byte(input logic [7:0] b);
        file_q = {file_q, b};
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            append_byte(w[8 * i +: 8]);
    endtask

    task automatic push_header();
        push_word(rce_pkg::TAG_RIFF);
        push_word($urandom);
        push_word(rce_pkg::TAG_WAVE);
    endtask

    task automatic push_body(input int n);
        repeat (n) append_byte(8'($urandom));
    endtask

    function automatic logic [31:0] pick_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return $urandom_range(0, 9);
        else if (sel < 17)
            return $urandom_range(10, 40);
        else if (sel == 17)
            return 32'hFFFF_FFFF;
        else if (sel == 18)
            return $urandom;
        else
            return 32'h0;
    endfunction

    // Build one random file into file_q.
    task automatic build_file();
        int          n_chunks;
        int          idx;
        int          cut;
        logic [32:0] body;
        logic [31:0] chunk_id;
        logic [31:0] chunk_len;
        bit          stop;
        file_q.delete();
        stop = 1'b0;
        if ($urandom_range(0, 9) == 0)
            push_body($urandom_range(1, 20));
        else
        begin
            push_header();
            if ($urandom_range(0, 9) == 0)
            begin
                // hit one tag byte
                idx = $urandom_range(0, 7);
                if (idx >= 4)
                    idx += 4;
                file_q[idx] ^= 8'($urandom_range(1, 255));
            end
            n_chunks = $urandom_range(0, 3);
            for (int c = 0; c < n_chunks && !stop; c++)
            begin
                chunk_id = $urandom_range(0, 1) ? $urandom
                                                : target_id ^ (32'h1 << $urandom_range(0, 31));
                if (chunk_id == target_id)
                    chunk_id = ~target_id;
                chunk_len = pick_len();
                push_word(chunk_id);
                push_word(chunk_len);
                body = {1'b0, chunk_len} + 33'(chunk_len[0]);
                if (body > BODY_CAP)
                begin
                    push_body($urandom_range(0, BODY_CAP));
                    stop = 1'b1;
                end
                else
                    push_body(int'(body));
            end
            if (!stop && $urandom_range(0, 4) != 0)
            begin
                chunk_len = pick_len();
                push_word(target_id);
                push_word(chunk_len);
                if (chunk_len > BODY_CAP)
                begin
                    push_body($urandom_range(0, BODY_CAP));
                    stop = 1'b1;
                end
                else
                    push_body(int'(chunk_len));
            end
            if (!stop)
                push_body($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, file_q.size());
                while (file_q.size() > cut)
                    void'(file_q.pop_back());
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        bit took;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        // ready is stable between the falling edge and the next rising edge
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
        bytes_sent += file_q.size();
    endtask

    task automatic run_files(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
        begin
            build_file();
            send_file();
        end
    endtask

    // Hold the input until every predicted output has left, then let the
    // pipeline flush bytes that produce nothing.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        target_id    = v;
    endtask

    initial
    begin
        logic [31:0] v;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte file: short header
        file_q.delete();
        append_byte(8'h00);
        send_file();
        // header only: end of file right after the header
        file_q.delete();
        push_header();
        send_file();
        // one-byte payload ending at end of file
        file_q.delete();
        push_header();
        push_word(rce_pkg::TAG_IXML);
        push_word(32'd1);
        append_byte(8'hFF);
        send_file();
        // empty match, then a byte that is dropped
        file_q.delete();
        push_header();
        push_word(rce_pkg::TAG_IXML);
        push_word(32'd0);
        append_byte(8'h00);
        send_file();
        // payload cut by end of file
        file_q.delete();
        push_header();
        push_word(rce_pkg::TAG_IXML);
        push_word(32'd3);
        append_byte(8'hA5);
        append_byte(8'h5A);
        send_file();

        run_files(PHASE_BYTES);
        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            case (p)
                0: v = 32'h0000_0000;
                1: v = 32'hFFFF_FFFF;
                2: v = 32'h6174_6164;
                3: v = $urandom;
                default: v = rce_pkg::TAG_IXML;
            endcase
            write_target(v);
            if (p == 4)
                quiet = 1'b1;
            run_files(PHASE_BYTES);
        end

        wait_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
